### design/cti_pkg.sv
// Shared types and constants of the clipped triangle attribute interpolator.
package cti_pkg;

	localparam int MAX_VERTS_DEF = 8;
	localparam int WORD_W        = 32;
	localparam int ATTR_N        = 6;
	localparam int FRAC_W        = 16;
	localparam int DIV_STEPS     = 49;

	localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [31:0] T_LIMIT = 32'sh4000_0000;

	// attribute slots: depth, u, v, red, green, blue
	localparam logic [2:0] ATTR_U    = 3'd1;
	localparam logic [2:0] ATTR_V    = 3'd2;
	localparam logic [2:0] ATTR_RED  = 3'd3;
	localparam logic [2:0] ATTR_DONE = 3'd6;

	typedef enum logic [1:0] {
		REG_GOURAUD = 2'd0,
		REG_TEXTURE = 2'd1,
		REG_NUDGE   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_DIV  = 2'b01,
		OP_LERP = 2'b10
	} arith_op_t;

	typedef struct packed {
		logic               start;
		arith_op_t          op;
		logic signed [32:0] opa;
		logic signed [32:0] opb;
		logic signed [31:0] t;
	} arith_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] result;
	} arith_rsp_t;

endpackage

### design/cti_ram.sv
// Generic single-port-write, registered-read RAM.
module cti_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = cti_pkg::MAX_VERTS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/cti_arith.sv
// Shared arithmetic unit: serial Q16.16 fraction divider and linear interpolation.
module cti_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  cti_pkg::arith_req_t req,
	output cti_pkg::arith_rsp_t rsp
);

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_DIV  = 4'b0010,
		A_MUL  = 4'b0100,
		A_ADD  = 4'b1000
	} astate_t;

	astate_t            st_q;
	logic [32:0]        rem_q;
	logic [48:0]        quo_q;
	logic [32:0]        dvs_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               dz_q;
	logic signed [31:0] a_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] t_q;
	logic signed [64:0] prod_q;
	logic signed [31:0] res_q;
	logic               done_q;

	logic [32:0]        abs_num;
	logic [32:0]        abs_den;
	logic [33:0]        trial;
	logic               ge;
	logic [33:0]        sub;
	logic [48:0]        q_new;
	logic signed [31:0] q_sat;
	logic signed [49:0] sum;
	logic signed [31:0] sum_sat;

	always_comb begin
		abs_num = req.opa[32] ? 33'(-req.opa) : 33'(req.opa);
		abs_den = req.opb[32] ? 33'(-req.opb) : 33'(req.opb);
		trial   = {rem_q, quo_q[48]};
		ge      = trial >= {1'b0, dvs_q};
		sub     = trial - {1'b0, dvs_q};
		q_new   = {quo_q[47:0], ge};
		q_sat   = (q_new > 49'(cti_pkg::T_LIMIT)) ? cti_pkg::T_LIMIT : 32'(q_new);
		sum     = 50'(a_q) + 50'(prod_q >>> cti_pkg::FRAC_W);
		if (sum > 50'sd2147483647) begin
			sum_sat = 32'sh7FFF_FFFF;
		end else if (sum < -50'sd2147483648) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = 32'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						if (req.op == cti_pkg::OP_DIV) begin
							st_q <= A_DIV;
						end else begin
							st_q <= A_MUL;
						end
					end
				end
				A_DIV: begin
					if (cnt_q == 6'd1) begin
						st_q   <= A_IDLE;
						done_q <= 1'b1;
					end
				end
				A_MUL: st_q <= A_ADD;
				A_ADD: begin
					st_q   <= A_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: begin
				if (req.start) begin
					rem_q  <= '0;
					quo_q  <= {abs_num, 16'd0};
					dvs_q  <= abs_den;
					cnt_q  <= 6'(cti_pkg::DIV_STEPS);
					neg_q  <= req.opa[32] ^ req.opb[32];
					dz_q   <= (req.opb == '0);
					a_q    <= 32'(req.opa);
					diff_q <= req.opb - req.opa;
					t_q    <= req.t;
				end
			end
			A_DIV: begin
				// one quotient bit per cycle
				rem_q <= ge ? sub[32:0] : trial[32:0];
				quo_q <= q_new;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					res_q <= dz_q ? '0 : (neg_q ? -q_sat : q_sat);
				end
			end
			A_MUL: prod_q <= 65'(diff_q) * 65'(t_q);
			A_ADD: res_q  <= sum_sat;
			default: ;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

### design/clipped_triangle_attribute_interpolator.sv
// Top level: corner and vertex capture, emission sequencer and register port.
//
// Corner and vertex items are accepted while the sequencer is idle. The vertex item
// marked last starts emission; no input is taken until the final vertex has been
// transferred. An unclipped polygon passes each vertex through the read, setup and
// output states without the shared unit. A clipped vertex needs three Q16.16 fractions
// through the serial divider (one quotient bit a cycle, 49 steps), then up to twenty
// interpolations on the same shared unit; disabled texture or colour skips their interpolations.
// The vertex store is a RAM of MAX_VERTS entries; the three corners sit in flops.
module clipped_triangle_attribute_interpolator #(
	parameter int MAX_VERTS = cti_pkg::MAX_VERTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // pos_x, pos_y, depth_in, tex_u_in, tex_v_in, red_in, green_in, blue_in
	input  logic [0:0]   s_tuser,  // func
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata,  // out_x, out_y, out_depth, out_u, out_v, out_red, out_green, out_blue
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CNT_W = $clog2(MAX_VERTS + 1);
	localparam int AW    = $clog2(MAX_VERTS);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_PREP  = 14'b00000000000010,
		S_RD    = 14'b00000000000100,
		S_SETUP = 14'b00000000001000,
		S_TL    = 14'b00000000010000,
		S_TR    = 14'b00000000100000,
		S_XL    = 14'b00000001000000,
		S_XR    = 14'b00000010000000,
		S_TX    = 14'b00000100000000,
		S_ASEL  = 14'b00001000000000,
		S_AL    = 14'b00010000000000,
		S_AR    = 14'b00100000000000,
		S_AX    = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t             st_q;
	logic               go_q;
	logic               gour_q;
	logic               tex_q;
	logic [15:0]        nudge_q;
	logic [1:0]         ccnt_q;
	logic [CNT_W-1:0]   vcnt_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   j_q;
	logic               clip_q;
	logic               clipped_q;
	logic signed [31:0] cs_q [3][8];
	logic signed [31:0] ncx_q [3];
	logic [1:0]         top_q, bl0_q, br0_q;
	logic [1:0]         vtl_q, vtr_q, vbl_q, vbr_q;
	logic signed [31:0] vx_q, vy_q;
	logic signed [31:0] tl_q, tr_q, tx_q, xl_q, xr_q, vl_q, vr_q;
	logic signed [31:0] res_q [cti_pkg::ATTR_N];
	logic [2:0]         a_q;

	cti_pkg::arith_req_t req;
	cti_pkg::arith_rsp_t rsp;

	logic               acc;
	logic               cfg_wr;
	logic               ram_we;
	logic               ram_re;
	logic [63:0]        ram_rdata;
	logic [1:0]         cmp_idx;
	logic signed [31:0] in_x, in_y;
	logic signed [16:0] rcy [3];
	logic signed [16:0] ry;
	logic [1:0]         top_c, bl0_c, br0_c;
	logic signed [31:0] ncx_c [3];
	logic [2:0]         attr_k;

	assign in_x     = s_tdata[31:0];
	assign in_y     = s_tdata[63:32];
	assign s_tready = (st_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign cmp_idx  = (vcnt_q < CNT_W'(3)) ? vcnt_q[1:0] : 2'd0;
	assign ram_we   = acc && s_tuser[0] && (vcnt_q < CNT_W'(MAX_VERTS));
	assign ram_re   = (st_q == S_RD);
	assign attr_k   = a_q + 3'd2;

	cti_ram #(.WIDTH(64), .DEPTH(MAX_VERTS)) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vcnt_q[AW-1:0]),
		.wdata ({in_y, in_x}),
		.re    (ram_re),
		.raddr (j_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	cti_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gour_q  <= 1'b0;
			tex_q   <= 1'b0;
			nudge_q <= 16'd1;
		end else if (cfg_wr) begin
			unique case (cti_pkg::reg_idx_t'(paddr[3:2]))
				cti_pkg::REG_GOURAUD: gour_q  <= pwdata[0];
				cti_pkg::REG_TEXTURE: tex_q   <= pwdata[0];
				cti_pkg::REG_NUDGE:   nudge_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cti_pkg::reg_idx_t'(paddr[3:2]))
			cti_pkg::REG_GOURAUD: prdata = {31'd0, gour_q};
			cti_pkg::REG_TEXTURE: prdata = {31'd0, tex_q};
			cti_pkg::REG_NUDGE:   prdata = {16'd0, nudge_q};
			default:              prdata = '0;
		endcase
	end

	// edge setup from the stored corners
	always_comb begin
		logic signed [32:0] nsub;
		for (int i = 0; i < 3; i++) begin
			rcy[i] = 17'((33'(cs_q[i][1]) + 33'sd32768) >>> cti_pkg::FRAC_W);
		end
		ry = 17'((33'(signed'(ram_rdata[63:32])) + 33'sd32768) >>> cti_pkg::FRAC_W);
		if (cs_q[0][1] < cs_q[1][1]) begin
			top_c = (cs_q[0][1] < cs_q[2][1]) ? 2'd0 : 2'd2;
		end else begin
			top_c = (cs_q[1][1] < cs_q[2][1]) ? 2'd1 : 2'd2;
		end
		bl0_c = (top_c == 2'd0) ? 2'd2 : top_c - 2'd1;
		br0_c = (top_c == 2'd2) ? 2'd0 : top_c + 2'd1;
		for (int i = 0; i < 3; i++) begin
			nsub     = 33'(cs_q[i][0]) - 33'(signed'({16'd0, nudge_q}));
			ncx_c[i] = cs_q[i][0];
			if ((2'(i) == bl0_c || 2'(i) == br0_c) && cs_q[i][0] == cs_q[top_c][0]
				&& cs_q[i][1] == cs_q[top_c][1]) begin
				ncx_c[i] = (nsub < -33'sd2147483648) ? 32'sh8000_0000 : 32'(nsub);
			end
		end
	end

	// operand selection for the shared unit
	always_comb begin
		req       = '0;
		req.start = go_q;
		req.op    = cti_pkg::OP_DIV;
		unique case (st_q)
			S_TL: begin
				if (rcy[vbl_q] != rcy[vtl_q]) begin
					req.opa = 33'(vy_q) - 33'(cs_q[vtl_q][1]);
					req.opb = 33'(cs_q[vbl_q][1]) - 33'(cs_q[vtl_q][1]);
				end else begin
					req.opa = 33'(vx_q) - 33'(ncx_q[vtl_q]);
					req.opb = 33'(ncx_q[vbl_q]) - 33'(ncx_q[vtl_q]);
				end
			end
			S_TR: begin
				if (rcy[vbr_q] != rcy[vtr_q]) begin
					req.opa = 33'(vy_q) - 33'(cs_q[vtr_q][1]);
					req.opb = 33'(cs_q[vbr_q][1]) - 33'(cs_q[vtr_q][1]);
				end else begin
					req.opa = 33'(vx_q) - 33'(ncx_q[vtr_q]);
					req.opb = 33'(ncx_q[vbr_q]) - 33'(ncx_q[vtr_q]);
				end
			end
			S_XL: begin
				req.op  = cti_pkg::OP_LERP;
				req.opa = 33'(ncx_q[vtl_q]);
				req.opb = 33'(ncx_q[vbl_q]);
				req.t   = tl_q;
			end
			S_XR: begin
				req.op  = cti_pkg::OP_LERP;
				req.opa = 33'(ncx_q[vtr_q]);
				req.opb = 33'(ncx_q[vbr_q]);
				req.t   = tr_q;
			end
			S_TX: begin
				req.opa = 33'(vx_q) - 33'(xl_q);
				req.opb = 33'(xr_q) - 33'(xl_q);
			end
			S_AL: begin
				req.op  = cti_pkg::OP_LERP;
				req.opa = 33'(cs_q[vtl_q][attr_k]);
				req.opb = 33'(cs_q[vbl_q][attr_k]);
				req.t   = tl_q;
			end
			S_AR: begin
				req.op  = cti_pkg::OP_LERP;
				req.opa = 33'(cs_q[vtr_q][attr_k]);
				req.opb = 33'(cs_q[vbr_q][attr_k]);
				req.t   = tr_q;
			end
			S_AX: begin
				req.op  = cti_pkg::OP_LERP;
				req.opa = 33'(vl_q);
				req.opb = 33'(vr_q);
				req.t   = tx_q;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			go_q   <= 1'b0;
			ccnt_q <= '0;
			vcnt_q <= '0;
			clip_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (acc && !s_tuser[0]) begin
						ccnt_q <= (ccnt_q == 2'd2) ? 2'd0 : ccnt_q + 2'd1;
					end else if (acc) begin
						if (vcnt_q < CNT_W'(MAX_VERTS)) begin
							vcnt_q <= vcnt_q + CNT_W'(1);
							if (vcnt_q >= CNT_W'(3) || in_x != cs_q[cmp_idx][0]
								|| in_y != cs_q[cmp_idx][1]) begin
								clip_q <= 1'b1;
							end
						end
						if (s_tlast) begin
							st_q <= S_PREP;
						end
					end
				end
				S_PREP:  st_q <= S_RD;
				S_RD:    st_q <= S_SETUP;
				S_SETUP: begin
					if (clipped_q) begin
						st_q <= S_TL;
						go_q <= 1'b1;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_TL: if (rsp.done) begin st_q <= S_TR; go_q <= 1'b1; end
				S_TR: if (rsp.done) begin st_q <= S_XL; go_q <= 1'b1; end
				S_XL: if (rsp.done) begin st_q <= S_XR; go_q <= 1'b1; end
				S_XR: if (rsp.done) begin st_q <= S_TX; go_q <= 1'b1; end
				S_TX: if (rsp.done) st_q <= S_ASEL;
				S_ASEL: begin
					if (a_q == cti_pkg::ATTR_DONE) begin
						st_q <= S_OUT;
					end else if (!((a_q == cti_pkg::ATTR_U || a_q == cti_pkg::ATTR_V) && !tex_q)
						&& !(a_q >= cti_pkg::ATTR_RED && !gour_q)) begin
						st_q <= S_AL;
						go_q <= 1'b1;
					end
				end
				S_AL: if (rsp.done) begin st_q <= S_AR; go_q <= 1'b1; end
				S_AR: if (rsp.done) begin st_q <= S_AX; go_q <= 1'b1; end
				S_AX: if (rsp.done) st_q <= S_ASEL;
				S_OUT: begin
					if (m_tready) begin
						if (j_q == n_q - CNT_W'(1)) begin
							st_q   <= S_IDLE;
							vcnt_q <= '0;
							ccnt_q <= '0;
							clip_q <= 1'b0;
						end else begin
							st_q <= S_RD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (acc && !s_tuser[0]) begin
					for (int k = 0; k < 8; k++) begin
						cs_q[ccnt_q][k] <= s_tdata[32*k +: 32];
					end
				end else if (acc && s_tlast) begin
					n_q <= (vcnt_q < CNT_W'(MAX_VERTS)) ? vcnt_q + CNT_W'(1) : vcnt_q;
				end
			end
			S_PREP: begin
				clipped_q <= clip_q || (n_q != CNT_W'(3));
				top_q     <= top_c;
				bl0_q     <= bl0_c;
				br0_q     <= br0_c;
				ncx_q     <= ncx_c;
				j_q       <= '0;
			end
			S_SETUP: begin
				vx_q <= ram_rdata[31:0];
				vy_q <= ram_rdata[63:32];
				a_q  <= '0;
				for (int i = 0; i < cti_pkg::ATTR_N; i++) begin
					res_q[i] <= (j_q < CNT_W'(3)) ? cs_q[j_q[1:0]][i + 2] : '0;
				end
				vtl_q <= top_q;
				vtr_q <= top_q;
				vbl_q <= bl0_q;
				vbr_q <= br0_q;
				// step past the middle corner on whichever side it lies
				if (ry > rcy[bl0_q]) begin
					vtl_q <= bl0_q;
					vbl_q <= (bl0_q == 2'd0) ? 2'd2 : bl0_q - 2'd1;
				end else if (ry > rcy[br0_q]) begin
					vtr_q <= br0_q;
					vbr_q <= (br0_q == 2'd2) ? 2'd0 : br0_q + 2'd1;
				end
			end
			S_TL: if (rsp.done) tl_q <= rsp.result;
			S_TR: if (rsp.done) tr_q <= rsp.result;
			S_XL: if (rsp.done) xl_q <= rsp.result;
			S_XR: if (rsp.done) xr_q <= rsp.result;
			S_TX: if (rsp.done) tx_q <= rsp.result;
			S_ASEL: begin
				if (a_q != cti_pkg::ATTR_DONE) begin
					if ((a_q == cti_pkg::ATTR_U || a_q == cti_pkg::ATTR_V) && !tex_q) begin
						a_q <= a_q + 3'd1;
					end else if (a_q >= cti_pkg::ATTR_RED && !gour_q) begin
						res_q[a_q] <= cti_pkg::Q_ONE;
						a_q        <= a_q + 3'd1;
					end
				end
			end
			S_AL: if (rsp.done) vl_q <= rsp.result;
			S_AR: if (rsp.done) vr_q <= rsp.result;
			S_AX: begin
				if (rsp.done) begin
					res_q[a_q] <= rsp.result;
					a_q        <= a_q + 3'd1;
				end
			end
			S_OUT: if (m_tready) j_q <= j_q + CNT_W'(1);
			default: ;
		endcase
	end

	assign m_tvalid = (st_q == S_OUT);
	assign m_tlast  = (j_q == n_q - CNT_W'(1));
	assign m_tdata  = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0], vy_q, vx_q};

	a_no_input_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during emission");

	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CNT_W'(MAX_VERTS)) else $error("vertex count beyond store");

	a_ccnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q != 2'd3) else $error("corner count out of range");

	a_polygon_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (vcnt_q == '0 && ccnt_q == 2'd0 && !clip_q))
		else $error("polygon state not cleared after final transfer");

	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (st_q == S_TL || st_q == S_TR || st_q == S_XL || st_q == S_XR
			|| st_q == S_TX || st_q == S_AL || st_q == S_AR || st_q == S_AX))
		else $error("arithmetic result outside an operation state");

endmodule
